// ===== rtl/core/jdc_pkg.sv =====
// ----------------------------------------------------------------------------
// jdc_pkg
// Shared widths, stage count and division constants for the Julian day
// to calendar converter.
// ----------------------------------------------------------------------------
package jdc_pkg;

    localparam int NUM_STAGES = 8;

    localparam int DAY_W   = 23;
    localparam int MS_W    = 27;
    localparam int YEAR_W  = 16;
    localparam int MONTH_W = 4;
    localparam int DOM_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int MSEC_W  = 10;

    // Date path
    localparam logic [DAY_W-1:0] GREG_START = 23'd2299161;
    localparam logic [24:0]      GREG_OFS   = 25'd7468865;

    // Reciprocals: ceil(2^s / d), exact floor over the operand range
    localparam int          DIV_I_SH  = 43;
    localparam logic [63:0] DIV_I_DEN = 64'd146097;
    localparam logic [25:0] DIV_I_MUL =
        26'(((64'd1 << DIV_I_SH) + DIV_I_DEN - 64'd1) / DIV_I_DEN);

    localparam int          DIV_C_SH  = 41;
    localparam logic [63:0] DIV_C_DEN = 64'd7305;
    localparam logic [28:0] DIV_C_MUL =
        29'(((64'd1 << DIV_C_SH) + DIV_C_DEN - 64'd1) / DIV_C_DEN);

    localparam int          DIV_T_SH  = 20;
    localparam logic [63:0] DIV_T_DEN = 64'd153;
    localparam logic [12:0] DIV_T_MUL =
        13'(((64'd1 << DIV_T_SH) + DIV_T_DEN - 64'd1) / DIV_T_DEN);

    // Time path
    localparam logic [MS_W-1:0] MS_DAY_MAX    = 27'd86399999;
    localparam logic [MS_W-1:0] MS_PER_HOUR   = 27'd3600000;
    localparam logic [21:0]     MS_PER_MINUTE = 22'd60000;
    localparam logic [15:0]     MS_PER_SECOND = 16'd1000;

    localparam int          DIV_H_SH  = 49;
    localparam logic [63:0] DIV_H_DEN = 64'd3600000;
    localparam logic [27:0] DIV_H_MUL =
        28'(((64'd1 << DIV_H_SH) + DIV_H_DEN - 64'd1) / DIV_H_DEN);

    localparam int          DIV_M_SH  = 38;
    localparam logic [63:0] DIV_M_DEN = 64'd60000;
    localparam logic [22:0] DIV_M_MUL =
        23'(((64'd1 << DIV_M_SH) + DIV_M_DEN - 64'd1) / DIV_M_DEN);

    localparam int          DIV_S_SH  = 26;
    localparam logic [63:0] DIV_S_DEN = 64'd1000;
    localparam logic [16:0] DIV_S_MUL =
        17'(((64'd1 << DIV_S_SH) + DIV_S_DEN - 64'd1) / DIV_S_DEN);

    // floor(30.6001 * t)
    function automatic logic [8:0] month_days(input logic [3:0] t);
        logic [8:0] v;
        unique case (t)
            4'd0:  v = 9'd0;
            4'd1:  v = 9'd30;
            4'd2:  v = 9'd61;
            4'd3:  v = 9'd91;
            4'd4:  v = 9'd122;
            4'd5:  v = 9'd153;
            4'd6:  v = 9'd183;
            4'd7:  v = 9'd214;
            4'd8:  v = 9'd244;
            4'd9:  v = 9'd275;
            4'd10: v = 9'd306;
            4'd11: v = 9'd336;
            4'd12: v = 9'd367;
            4'd13: v = 9'd397;
            4'd14: v = 9'd428;
            4'd15: v = 9'd459;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/jdc_ifs.sv =====
// ----------------------------------------------------------------------------
// jdc_ifs
// Request and response channels of the Julian day to calendar converter.
// ----------------------------------------------------------------------------
interface jdc_req_if import jdc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DAY_W-1:0]  day_number;
    logic [MS_W-1:0]   ms_of_day;

    modport source (output valid, day_number, ms_of_day, input ready);
    modport sink   (input valid, day_number, ms_of_day, output ready);
endinterface

interface jdc_rsp_if import jdc_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [YEAR_W-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [DOM_W-1:0]         day_of_month;
    logic [HOUR_W-1:0]        hour;
    logic [MIN_W-1:0]         minute;
    logic [SEC_W-1:0]         second;
    logic [MSEC_W-1:0]        millisecond;

    modport source (output valid, year, month, day_of_month, hour, minute, second,
                    millisecond, input ready);
    modport sink   (input valid, year, month, day_of_month, hour, minute, second,
                    millisecond, output ready);
endinterface

// ===== rtl/core/jdc_date.sv =====
// ----------------------------------------------------------------------------
// jdc_date
// Eight-stage date pipeline: day number to year, month and day of month.
// ----------------------------------------------------------------------------
module jdc_date import jdc_pkg::*; (
    input  logic                     i_clk,
    input  logic [NUM_STAGES-1:0]    i_en,
    input  logic [DAY_W-1:0]         i_day_number,
    output logic signed [YEAR_W-1:0] o_year,
    output logic [MONTH_W-1:0]       o_month,
    output logic [DOM_W-1:0]         o_day_of_month
);

    // stage 1
    logic             n1_greg;
    logic [24:0]      n1_x;
    logic             r1_greg;
    logic [24:0]      r1_x;
    logic [DAY_W-1:0] r1_z;

    assign n1_greg = (i_day_number >= GREG_START);
    assign n1_x    = {i_day_number, 2'b00} - GREG_OFS;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_greg <= n1_greg;
            r1_x    <= n1_x;
            r1_z    <= i_day_number;
        end
    end

    // stage 2: century count
    logic [50:0]      prod_i;
    logic [7:0]       n2_i;
    logic [7:0]       r2_i;
    logic             r2_greg;
    logic [DAY_W-1:0] r2_z;

    assign prod_i = 51'(r1_x) * 51'(DIV_I_MUL);
    assign n2_i   = prod_i[DIV_I_SH +: 8];

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_i    <= n2_i;
            r2_greg <= r1_greg;
            r2_z    <= r1_z;
        end
    end

    // stage 3: b
    logic [23:0] n3_ofs;
    logic [23:0] n3_b;
    logic [23:0] r3_b;

    assign n3_ofs = r2_greg ? (24'd1525 + 24'(r2_i) - 24'(r2_i >> 2)) : 24'd1524;
    assign n3_b   = {1'b0, r2_z} + n3_ofs;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_b <= n3_b;
        end
    end

    // stage 4: 20b - 2442
    logic [27:0] n4_y;
    logic [27:0] r4_y;
    logic [23:0] r4_b;

    assign n4_y = 28'(r3_b) * 28'd20 - 28'd2442;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_y <= n4_y;
            r4_b <= r3_b;
        end
    end

    // stage 5: c
    logic [56:0] prod_c;
    logic [14:0] n5_c;
    logic [14:0] r5_c;
    logic [23:0] r5_b;

    assign prod_c = 57'(r4_y) * 57'(DIV_C_MUL);
    assign n5_c   = prod_c[DIV_C_SH +: 15];

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r5_c <= n5_c;
            r5_b <= r4_b;
        end
    end

    // stage 6: day within the year, both year candidates
    logic [25:0] n6_prod;
    logic [23:0] n6_diff;
    logic [15:0] n6_yr_a;
    logic [15:0] n6_yr_b;
    logic [8:0]  r6_bd;
    logic [15:0] r6_yr_a;
    logic [15:0] r6_yr_b;

    assign n6_prod = 26'(r5_c) * 26'd1461;
    assign n6_diff = r5_b - 24'(n6_prod >> 2);
    assign n6_yr_a = {1'b0, r5_c} - 16'd4716;
    assign n6_yr_b = {1'b0, r5_c} - 16'd4715;

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r6_bd   <= n6_diff[8:0];
            r6_yr_a <= n6_yr_a;
            r6_yr_b <= n6_yr_b;
        end
    end

    // stage 7: month estimate t
    logic [11:0] n7_bd5;
    logic [24:0] prod_t;
    logic [3:0]  r7_t;
    logic [8:0]  r7_bd;
    logic [15:0] r7_yr_a;
    logic [15:0] r7_yr_b;

    assign n7_bd5 = {1'b0, r6_bd, 2'b00} + {3'b000, r6_bd};
    assign prod_t = 25'(n7_bd5) * 25'(DIV_T_MUL);

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r7_t    <= prod_t[DIV_T_SH +: 4];
            r7_bd   <= r6_bd;
            r7_yr_a <= r6_yr_a;
            r7_yr_b <= r6_yr_b;
        end
    end

    // stage 8: day of month with step-back, month, year
    logic [8:0]         n8_sub;
    logic [8:0]         n8_sub_p;
    logic [3:0]         n8_t_p;
    logic [8:0]         n8_dom0;
    logic [8:0]         n8_dom1;
    logic               n8_retry;
    logic [3:0]         n8_t;
    logic [8:0]         n8_dom;
    logic [MONTH_W-1:0] n8_month;
    logic [15:0]        n8_year;
    logic [15:0]        r8_year;
    logic [MONTH_W-1:0] r8_month;
    logic [DOM_W-1:0]   r8_dom;

    assign n8_t_p   = r7_t - 4'd1;
    assign n8_sub   = month_days(r7_t);
    assign n8_sub_p = month_days(n8_t_p);
    assign n8_dom0  = (r7_bd >= n8_sub) ? (r7_bd - n8_sub) : 9'd0;
    assign n8_dom1  = (r7_bd >= n8_sub_p) ? (r7_bd - n8_sub_p) : 9'd0;
    assign n8_retry = (n8_dom0 == 9'd0) && (r7_t != 4'd0);
    assign n8_t     = n8_retry ? n8_t_p : r7_t;
    assign n8_dom   = n8_retry ? n8_dom1 : n8_dom0;
    assign n8_month = (n8_t < 4'd14) ? (n8_t - 4'd1) : (n8_t - 4'd13);
    assign n8_year  = (n8_month > 4'd2) ? r7_yr_a : r7_yr_b;

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r8_year  <= n8_year;
            r8_month <= n8_month;
            r8_dom   <= n8_dom[DOM_W-1:0];
        end
    end

    assign o_year         = signed'(r8_year);
    assign o_month        = r8_month;
    assign o_day_of_month = r8_dom;

endmodule

// ===== rtl/core/jdc_time.sv =====
// ----------------------------------------------------------------------------
// jdc_time
// Eight-stage time pipeline: millisecond of day to hour, minute, second and
// millisecond.
// ----------------------------------------------------------------------------
module jdc_time import jdc_pkg::*; (
    input  logic                  i_clk,
    input  logic [NUM_STAGES-1:0] i_en,
    input  logic [MS_W-1:0]       i_ms_of_day,
    output logic [HOUR_W-1:0]     o_hour,
    output logic [MIN_W-1:0]      o_minute,
    output logic [SEC_W-1:0]      o_second,
    output logic [MSEC_W-1:0]     o_millisecond
);

    // stage 1: clamp to end of day
    logic [MS_W-1:0] n1_ms;
    logic [MS_W-1:0] r1_ms;

    assign n1_ms = (i_ms_of_day > MS_DAY_MAX) ? MS_DAY_MAX : i_ms_of_day;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_ms <= n1_ms;
        end
    end

    // stage 2: hour
    logic [54:0]       prod_h;
    logic [HOUR_W-1:0] r2_hour;
    logic [MS_W-1:0]   r2_ms;

    assign prod_h = 55'(r1_ms) * 55'(DIV_H_MUL);

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_hour <= prod_h[DIV_H_SH +: HOUR_W];
            r2_ms   <= r1_ms;
        end
    end

    // stage 3: ms within the hour
    logic [MS_W-1:0]   n3_diff;
    logic [21:0]       r3_rem;
    logic [HOUR_W-1:0] r3_hour;

    assign n3_diff = r2_ms - MS_W'(r2_hour) * MS_PER_HOUR;

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r3_rem  <= n3_diff[21:0];
            r3_hour <= r2_hour;
        end
    end

    // stage 4: minute
    logic [44:0]       prod_m;
    logic [MIN_W-1:0]  r4_min;
    logic [21:0]       r4_rem;
    logic [HOUR_W-1:0] r4_hour;

    assign prod_m = 45'(r3_rem) * 45'(DIV_M_MUL);

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r4_min  <= prod_m[DIV_M_SH +: MIN_W];
            r4_rem  <= r3_rem;
            r4_hour <= r3_hour;
        end
    end

    // stage 5: ms within the minute
    logic [21:0]       n5_diff;
    logic [15:0]       r5_rem;
    logic [MIN_W-1:0]  r5_min;
    logic [HOUR_W-1:0] r5_hour;

    assign n5_diff = r4_rem - 22'(r4_min) * MS_PER_MINUTE;

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r5_rem  <= n5_diff[15:0];
            r5_min  <= r4_min;
            r5_hour <= r4_hour;
        end
    end

    // stage 6: second
    logic [32:0]       prod_s;
    logic [SEC_W-1:0]  r6_sec;
    logic [15:0]       r6_rem;
    logic [MIN_W-1:0]  r6_min;
    logic [HOUR_W-1:0] r6_hour;

    assign prod_s = 33'(r5_rem) * 33'(DIV_S_MUL);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r6_sec  <= prod_s[DIV_S_SH +: SEC_W];
            r6_rem  <= r5_rem;
            r6_min  <= r5_min;
            r6_hour <= r5_hour;
        end
    end

    // stage 7: millisecond
    logic [15:0]       n7_diff;
    logic [MSEC_W-1:0] r7_msec;
    logic [SEC_W-1:0]  r7_sec;
    logic [MIN_W-1:0]  r7_min;
    logic [HOUR_W-1:0] r7_hour;

    assign n7_diff = r6_rem - 16'(r6_sec) * MS_PER_SECOND;

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r7_msec <= n7_diff[MSEC_W-1:0];
            r7_sec  <= r6_sec;
            r7_min  <= r6_min;
            r7_hour <= r6_hour;
        end
    end

    // stage 8: output register, aligned with the date path
    logic [MSEC_W-1:0] r8_msec;
    logic [SEC_W-1:0]  r8_sec;
    logic [MIN_W-1:0]  r8_min;
    logic [HOUR_W-1:0] r8_hour;

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r8_msec <= r7_msec;
            r8_sec  <= r7_sec;
            r8_min  <= r7_min;
            r8_hour <= r7_hour;
        end
    end

    assign o_hour        = r8_hour;
    assign o_minute      = r8_min;
    assign o_second      = r8_sec;
    assign o_millisecond = r8_msec;

endmodule

// ===== rtl/core/julian_day_to_calendar.sv =====
// ----------------------------------------------------------------------------
// julian_day_to_calendar
// Converts a Julian day number and millisecond of day into calendar date and
// time (Meeus method, Julian calendar before day 2299161, Gregorian from it on).
// One transfer is taken every cycle unless ready is low. The date and time
// paths are each eight register stages, with at most one reciprocal
// multiplier or multiply-subtract per stage and a valid bit per stage.
// Bubbles are squeezed out on a stall, so ready drops only when all eight
// stages hold items and the response is not taken. A millisecond count past
// the end of the day is clamped to 23:59:59.999 of the same day.
// ----------------------------------------------------------------------------
module julian_day_to_calendar import jdc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jdc_req_if.sink   i_req,
    jdc_rsp_if.source o_rsp
);

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES-1:0] stage_en;

    always_comb begin
        stage_en[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || o_rsp.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k+1];
        end
    end

    always_comb begin
        n_valid[0] = stage_en[0] ? i_req.valid : r_valid[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_valid[k] = stage_en[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign i_req.ready = stage_en[0];
    assign o_rsp.valid = r_valid[NUM_STAGES-1];

    jdc_date u_date (
        .i_clk          (i_clk),
        .i_en           (stage_en),
        .i_day_number   (i_req.day_number),
        .o_year         (o_rsp.year),
        .o_month        (o_rsp.month),
        .o_day_of_month (o_rsp.day_of_month)
    );

    jdc_time u_time (
        .i_clk         (i_clk),
        .i_en          (stage_en),
        .i_ms_of_day   (i_req.ms_of_day),
        .o_hour        (o_rsp.hour),
        .o_minute      (o_rsp.minute),
        .o_second      (o_rsp.second),
        .o_millisecond (o_rsp.millisecond)
    );

    // back-pressure only with a full pipe
    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (&r_valid))
        else $error("request stalled with a free stage");

    a_entry_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_valid[0])
        else $error("transfer not captured in first stage");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.month >= 4'd1 && o_rsp.month <= 4'd12 &&
                         o_rsp.day_of_month >= 5'd1 && o_rsp.day_of_month <= 5'd31))
        else $error("date out of range");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.hour <= 5'd23 && o_rsp.minute <= 6'd59 &&
                         o_rsp.second <= 6'd59 && o_rsp.millisecond <= 10'd999))
        else $error("time out of range");

endmodule

// ===== verif/julian_day_to_calendar_tb.sv =====
// ----------------------------------------------------------------------------
// julian_day_to_calendar_tb
// Self-checking bench for the Julian day to calendar converter. Requests
// come from a queue: a directed set at the field extremes, the calendar
// switch-over and the day-of-month refold, then random timestamps. Each
// request transfer is converted by an in-bench integer model, and each
// response transfer is compared field by field against the oldest pending
// date. The run has four phases: no idling, source idling, sink stalls, then both.
// ----------------------------------------------------------------------------
module julian_day_to_calendar_tb import jdc_pkg::*; ();

    localparam longint unsigned GREGORIAN_FIRST_DAY = 2299161;
    localparam longint unsigned MS_LAST_OF_DAY      = 86399999;
    localparam longint unsigned MS_FIELD_MAX        = (1 << MS_W) - 1;
    localparam longint unsigned DAY_FIELD_MAX       = (1 << DAY_W) - 1;
    localparam int              RANDOM_PER_PHASE    = 313;
    localparam int              NUM_PHASES          = 4;
    localparam int unsigned     CYCLE_LIMIT         = 200000;

    typedef struct packed {
        logic [DAY_W-1:0] day_number;
        logic [MS_W-1:0]  ms_of_day;
    } t_timestamp;

    typedef struct packed {
        logic signed [YEAR_W-1:0] year;
        logic [MONTH_W-1:0]       month;
        logic [DOM_W-1:0]         day_of_month;
        logic [HOUR_W-1:0]        hour;
        logic [MIN_W-1:0]         minute;
        logic [SEC_W-1:0]         second;
        logic [MSEC_W-1:0]        millisecond;
        logic                     refolded;
    } t_calendar;

    logic i_clk = 1'b0;
    logic i_rst_n;

    jdc_req_if req_ch ();
    jdc_rsp_if rsp_ch ();

    julian_day_to_calendar dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    t_timestamp   pending_stamps[$];
    t_calendar    expected_dates[$];
    int unsigned  src_idle_pct;
    int unsigned  snk_stall_pct;
    int unsigned  mismatch_count;
    int unsigned  cycle_count;
    logic         req_taken;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint unsigned days_past_month(input longint unsigned bd,
                                                        input longint unsigned t);
        longint unsigned sub;
        sub = (64'd306001 * t) / 64'd10000;
        return (bd >= sub) ? (bd - sub) : 64'd0;
    endfunction

    function automatic t_calendar convert_day(input logic [DAY_W-1:0] day_num,
                                              input logic [MS_W-1:0]  ms_in);
        t_calendar       r;
        longint unsigned z, ms, a, cent, b, c, bd, t, dom, mon;
        longint          yr;
        z  = day_num;
        ms = ms_in;
        if (z < GREGORIAN_FIRST_DAY) begin
            a = z;
        end else begin
            cent = (64'd4 * z - 64'd7468865) / 64'd146097;
            a    = z + 64'd1 + cent - cent / 64'd4;
        end
        b   = a + 64'd1524;
        c   = (64'd20 * b - 64'd2442) / 64'd7305;
        bd  = b - (64'd1461 * c) / 64'd4;
        t   = (64'd5 * bd) / 64'd153;
        dom = days_past_month(bd, t);
        r.refolded = 1'b0;
        if (dom == 0 && t > 0) begin
            t          = t - 64'd1;
            dom        = days_past_month(bd, t);
            r.refolded = 1'b1;
        end
        mon = (t < 14) ? (t - 64'd1) : (t - 64'd13);
        yr  = (mon > 2) ? (longint'(c) - 4716) : (longint'(c) - 4715);
        if (ms > MS_LAST_OF_DAY)
            ms = MS_LAST_OF_DAY;
        r.year         = yr[YEAR_W-1:0];
        r.month        = mon[MONTH_W-1:0];
        r.day_of_month = dom[DOM_W-1:0];
        r.hour         = 5'((ms / 64'd3600000) & 64'h1F);
        ms             = ms % 64'd3600000;
        r.minute       = 6'((ms / 64'd60000) & 64'h3F);
        ms             = ms % 64'd60000;
        r.second       = 6'((ms / 64'd1000) & 64'h3F);
        r.millisecond  = 10'((ms % 64'd1000) & 64'h3FF);
        return r;
    endfunction

    task automatic check_field(input string name, input int expv, input int actv);
        if (expv != actv) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
        end
    endtask

    task automatic queue_stamp(input longint unsigned day, input longint unsigned ms);
        t_timestamp s;
        s.day_number = day[DAY_W-1:0];
        s.ms_of_day  = ms[MS_W-1:0];
        pending_stamps.insert(pending_stamps.size(), s);
    endtask

    // Request driver
    always @(negedge i_clk) begin : req_driver
        t_timestamp s;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_taken) begin
            if (pending_stamps.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                s = pending_stamps.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.day_number <= s.day_number;
                req_ch.ms_of_day  <= s.ms_of_day;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
        rsp_ch.ready <= i_rst_n && ($urandom_range(99) >= snk_stall_pct);
    end

    // Transfer monitor and checker
    always @(posedge i_clk) begin : transfer_monitor
        t_calendar e;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end else if (i_rst_n) begin
            req_taken = req_ch.valid && req_ch.ready;
            if (req_taken)
                expected_dates.insert(expected_dates.size(),
                                      convert_day(req_ch.day_number, req_ch.ms_of_day));
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_dates.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected response, expected none, got %0d-%0d-%0d",
                             $time, rsp_ch.year, rsp_ch.month, rsp_ch.day_of_month);
                end else begin
                    e = expected_dates.pop_front();
                    check_field("year", e.year, rsp_ch.year);
                    check_field("month", e.month, rsp_ch.month);
                    check_field("day_of_month", e.day_of_month, rsp_ch.day_of_month);
                    check_field("hour", e.hour, rsp_ch.hour);
                    check_field("minute", e.minute, rsp_ch.minute);
                    check_field("second", e.second, rsp_ch.second);
                    check_field("millisecond", e.millisecond, rsp_ch.millisecond);
                end
            end
        end
    end

    initial begin : stimulus
        longint unsigned z, day, ms;
        int              found;
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.day_number = '0;
        req_ch.ms_of_day  = '0;
        rsp_ch.ready      = 1'b0;
        req_taken         = 1'b0;
        src_idle_pct      = 0;
        snk_stall_pct     = 0;
        mismatch_count    = 0;
        cycle_count       = 0;

        // Field extremes, calendar switch-over, clamped milliseconds
        queue_stamp(0, 0);
        queue_stamp(DAY_FIELD_MAX, MS_FIELD_MAX);
        queue_stamp(1, MS_LAST_OF_DAY);
        queue_stamp(DAY_FIELD_MAX - 1, MS_LAST_OF_DAY + 1);
        queue_stamp(GREGORIAN_FIRST_DAY - 2, 3599999);
        queue_stamp(GREGORIAN_FIRST_DAY - 1, 3600000);
        queue_stamp(GREGORIAN_FIRST_DAY, 59999);
        queue_stamp(GREGORIAN_FIRST_DAY + 1, 60000);
        queue_stamp(2451545, 999);
        queue_stamp(2415079, 1000);
        queue_stamp(2451604, 43200000);
        queue_stamp(2460000, MS_FIELD_MAX - 1);
        queue_stamp(1721424, 12345678);

        // Day-of-month refold, both calendars
        found = 0;
        for (z = GREGORIAN_FIRST_DAY - 400; found < 6 && z < GREGORIAN_FIRST_DAY + 2000;
             z++) begin
            if (convert_day(z[DAY_W-1:0], '0).refolded) begin
                queue_stamp(z, $urandom_range(MS_LAST_OF_DAY));
                found++;
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 73; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 73; end
                default: begin src_idle_pct = 10; snk_stall_pct = 10; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                case ($urandom_range(3))
                    0: day = $urandom_range(GREGORIAN_FIRST_DAY + 800,
                                            GREGORIAN_FIRST_DAY - 800);
                    1: day = $urandom_range(2500000, 2400000);
                    default: day = $urandom_range(DAY_FIELD_MAX);
                endcase
                if ($urandom_range(9) == 0)
                    ms = $urandom_range(MS_FIELD_MAX, MS_LAST_OF_DAY + 1);
                else
                    ms = $urandom_range(MS_LAST_OF_DAY);
                queue_stamp(day, ms);
            end
            while (pending_stamps.size() > 0 || req_ch.valid || expected_dates.size() > 0)
                @(posedge i_clk);
        end

        repeat (4 * NUM_STAGES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_dates.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/jdc_pkg.sv
rtl/core/jdc_ifs.sv
rtl/core/jdc_date.sv
rtl/core/jdc_time.sv
rtl/core/julian_day_to_calendar.sv
verif/julian_day_to_calendar_tb.sv
